FILE: hw/rtl/fte_pkg.sv
// ----------------------------------------------------------------------------
// fte_pkg
// types and constants shared by the tag event tracker
// ----------------------------------------------------------------------------
package fte_pkg;

	localparam int TableSizeDef = 32;
	localparam int MaxResults   = 32;

	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_APPEARED = 3'd1;
	localparam logic [2:0] EV_MOVED    = 3'd2;
	localparam logic [2:0] EV_GONE     = 3'd3;
	localparam logic [2:0] EV_DROPPED  = 3'd4;

	localparam logic [1:0] REG_LIM_PIX = 2'd0;
	localparam logic [1:0] REG_LIM_MET = 2'd1;
	localparam logic [1:0] REG_VANISH  = 2'd2;

	typedef struct packed {
		logic        req_type;
		logic [3:0]  tag_family;
		logic [15:0] tag_number;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [31:0] trans_x;
		logic [31:0] trans_y;
		logic [31:0] trans_z;
		logic [31:0] frame_number;
		logic        last_of_frame;
	} req_t;

	typedef struct packed {
		logic [2:0]  event_code;
		logic [3:0]  out_family;
		logic [15:0] out_tag;
		logic [15:0] out_center_x;
		logic [15:0] out_center_y;
		logic [31:0] out_trans_x;
		logic [31:0] out_trans_y;
		logic [31:0] out_trans_z;
		logic        run_last;
	} evt_t;

	// one table entry as held in memory
	typedef struct packed {
		logic        active;
		logic [3:0]  family;
		logic [15:0] tag;
		logic [15:0] cx;
		logic [15:0] cy;
		logic [31:0] tx;
		logic [31:0] ty;
		logic [31:0] tz;
		logic [31:0] seen;
	} entry_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [31:0] data;
	} cfg_t;

endpackage

FILE: hw/rtl/fte_if.sv
// ----------------------------------------------------------------------------
// fte_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface fte_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/fte_table.sv
// ----------------------------------------------------------------------------
// fte_table
// entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module fte_table import fte_pkg::*; #(
	parameter int TableSize = TableSizeDef,
	localparam int Aw = (TableSize > 1) ? $clog2(TableSize) : 1
) (
	input  logic          clk,
	input  logic [Aw-1:0] rd_addr,
	output entry_t        rd_data,
	input  logic          wr_en,
	input  logic [Aw-1:0] wr_addr,
	input  entry_t        wr_data
);
	entry_t mem [TableSize];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

FILE: hw/rtl/fte_dist.sv
// ----------------------------------------------------------------------------
// fte_dist
// squared distance accumulator, one component per cycle
// ----------------------------------------------------------------------------
module fte_dist import fte_pkg::*; (
	input  logic        clk,
	input  logic        start,
	input  logic [2:0]  step,
	input  req_t        req,
	input  entry_t      ent,
	input  logic [15:0] lim_pix,
	input  logic [30:0] lim_met,
	output logic        moved
);
	logic [32:0] a, b, d;
	logic [65:0] sq_s1;
	logic [63:0] dm_q;
	logic [32:0] dp_q;
	logic [64:0] sum;
	logic [31:0] lp;
	logic [61:0] lm;

	always_comb begin
		a = '0;
		b = '0;
		case (step)
			3'd0: begin a = {17'd0, req.pos_x}; b = {17'd0, ent.cx}; end
			3'd1: begin a = {17'd0, req.pos_y}; b = {17'd0, ent.cy}; end
			3'd2: begin a = {req.trans_x[31], req.trans_x}; b = {ent.tx[31], ent.tx}; end
			3'd3: begin a = {req.trans_y[31], req.trans_y}; b = {ent.ty[31], ent.ty}; end
			3'd4: begin a = {req.trans_z[31], req.trans_z}; b = {ent.tz[31], ent.tz}; end
			default: ;
		endcase
		d = ($signed(a) >= $signed(b)) ? a - b : b - a;
		sum = {1'b0, dm_q} + {1'b0, sq_s1[63:0]};
		lp = lim_pix * lim_pix;
		lm = lim_met * lim_met;
		moved = ({31'd0, dp_q} > {32'd0, lp}) || (dm_q > {2'd0, lm});
	end

	// square registered, then folded into the sum on the next step
	always_ff @(posedge clk) begin
		sq_s1 <= d * d;
		if (start) begin
			dp_q <= '0;
			dm_q <= '0;
		end else begin
			case (step)
				3'd1, 3'd2: dp_q <= dp_q + sq_s1[32:0];
				3'd3, 3'd4, 3'd5: dm_q <= sum[64] ? '1 : sum[63:0];
				default: ;
			endcase
		end
	end
endmodule

FILE: hw/rtl/fiducial_tag_event_tracker_top.sv
// ----------------------------------------------------------------------------
// fiducial_tag_event_tracker_top
// tag table tracker reporting appeared, moved, disappeared and dropped tags
// ----------------------------------------------------------------------------
// One item at a time. An observation walks the used entries through the
// table memory, one read a cycle, and its result beat follows the walk;
// a check walks them likewise, with extra steps for each report, and stalls
// while a result beat waits. Each disappeared beat is held back until the
// next one is found or the walk ends, so that the last beat of the run can
// be marked. The table needs no clearing after reset.
module fiducial_tag_event_tracker_top import fte_pkg::*; #(
	parameter int TableSize = TableSizeDef
) (
	input logic clk,
	input logic arst_n,
	fte_if.sink   req,
	fte_if.source evt,
	fte_if.sink   cfg
);
	localparam int Aw = (TableSize > 1) ? $clog2(TableSize) : 1;
	localparam int Cw = $clog2(TableSize + 1);
	localparam int Rw = $clog2(MaxResults + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SRCH = 3'd1;
	localparam logic [2:0] ST_DIST = 3'd2;
	localparam logic [2:0] ST_DONE = 3'd3;
	localparam logic [2:0] ST_SCAN = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]    state_q;
	req_t          req_q;
	logic [Cw-1:0] used_q, idx_q;
	logic          rd_vld_q;
	logic [2:0]    step_q;
	logic          new_q;
	logic [Rw-1:0] n_q;
	logic [15:0]   lim_pix_q, vanish_q;
	logic [30:0]   lim_met_q;
	entry_t        rd_data, ent_q, wr_data;
	logic          wr_en;
	logic [Aw-1:0] wr_addr, rd_addr;
	logic          moved;
	evt_t          out_q;
	logic          out_vld_q;
	logic          stg_q;
	logic [31:0]   age;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE) && !out_vld_q;
	assign evt.valid = out_vld_q;
	assign evt.data  = out_q;
	assign rd_addr   = idx_q[Aw-1:0];
	assign age       = req_q.frame_number - rd_data.seen;

	fte_table #(.TableSize(TableSize)) u_table (
		.clk, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
	);

	fte_dist u_dist (
		.clk, .start(state_q == ST_SRCH), .step(step_q), .req(req_q), .ent(ent_q),
		.lim_pix(lim_pix_q), .lim_met(lim_met_q), .moved
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_pix_q <= 16'd80;
			lim_met_q <= 31'd3277;
			vanish_q  <= 16'd30;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_LIM_PIX: lim_pix_q <= cfg.data.data[15:0];
				REG_LIM_MET: lim_met_q <= cfg.data.data[30:0];
				REG_VANISH:  vanish_q  <= cfg.data.data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[Aw-1:0];
		wr_data = ent_q;
		if (state_q == ST_DONE) begin
			wr_en   = 1'b1;
			wr_data = '{active: 1'b1, family: req_q.tag_family, tag: req_q.tag_number,
				cx: req_q.pos_x, cy: req_q.pos_y, tx: req_q.trans_x,
				ty: req_q.trans_y, tz: req_q.trans_z, seen: req_q.frame_number};
		end else if (state_q == ST_SCAN && rd_vld_q && rd_data.active
				&& age > {16'd0, vanish_q} && !out_vld_q && !stg_q) begin
			// the entry on rd_data was read from the address before idx_q
			wr_en   = 1'b1;
			wr_addr = Aw'(idx_q - Cw'(1));
			wr_data = rd_data;
			wr_data.active = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			used_q    <= '0;
			idx_q     <= '0;
			rd_vld_q  <= 1'b0;
			step_q    <= '0;
			new_q     <= 1'b0;
			n_q       <= '0;
			out_vld_q <= 1'b0;
			stg_q     <= 1'b0;
		end else begin
			if (evt.valid && evt.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						req_q    <= req.data;
						idx_q    <= '0;
						rd_vld_q <= 1'b0;
						n_q      <= '0;
						state_q  <= req.data.req_type ? ST_SCAN : ST_SRCH;
					end
				end
				ST_SRCH: begin
					// read of idx_q lands next cycle; compare the previous one
					if (rd_vld_q && rd_data.tag == req_q.tag_number
							&& rd_data.family == req_q.tag_family) begin
						ent_q   <= rd_data;
						idx_q   <= idx_q - Cw'(1);
						new_q   <= !rd_data.active;
						step_q  <= '0;
						state_q <= ST_DIST;
					end else if (idx_q == used_q) begin
						if (used_q == Cw'(TableSize)) begin
							out_q <= '{EV_DROPPED, req_q.tag_family, req_q.tag_number,
								req_q.pos_x, req_q.pos_y, req_q.trans_x,
								req_q.trans_y, req_q.trans_z, 1'b1};
							out_vld_q <= 1'b1;
							state_q   <= ST_IDLE;
						end else begin
							new_q   <= 1'b1;
							used_q  <= used_q + Cw'(1);
							step_q  <= 3'd5;
							state_q <= ST_DIST;
						end
					end else begin
						idx_q    <= idx_q + Cw'(1);
						rd_vld_q <= 1'b1;
					end
				end
				ST_DIST: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd6) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					out_q <= '{new_q ? EV_APPEARED : (moved ? EV_MOVED : EV_NONE),
						req_q.tag_family, req_q.tag_number, req_q.pos_x,
						req_q.pos_y, req_q.trans_x, req_q.trans_y, req_q.trans_z, 1'b1};
					out_vld_q <= 1'b1;
					state_q   <= ST_IDLE;
				end
				ST_SCAN: begin
					if (!out_vld_q) begin
						if (rd_vld_q && rd_data.active && age > {16'd0, vanish_q}) begin
							if (stg_q) begin
								// another one follows: send the held beat, read this entry again
								out_vld_q <= 1'b1;
								stg_q     <= 1'b0;
								rd_vld_q  <= 1'b0;
								idx_q     <= idx_q - Cw'(1);
							end else begin
								out_q <= '{EV_GONE, rd_data.family, rd_data.tag, rd_data.cx,
									rd_data.cy, rd_data.tx, rd_data.ty, rd_data.tz, 1'b0};
								stg_q    <= 1'b1;
								n_q      <= n_q + Rw'(1);
								rd_vld_q <= 1'b0;
								if (n_q + Rw'(1) == Rw'(MaxResults)) begin
									state_q <= ST_OUT;
								end
							end
						end else if (idx_q == used_q) begin
							state_q <= ST_OUT;
						end else begin
							idx_q    <= idx_q + Cw'(1);
							rd_vld_q <= 1'b1;
						end
					end
				end
				ST_OUT: begin
					// close the run: mark the held beat last, or send an empty one
					if (!out_vld_q) begin
						if (stg_q) begin
							out_q.run_last <= 1'b1;
						end else begin
							out_q <= '{EV_NONE, 4'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0,
								32'd0, 1'b1};
						end
						stg_q     <= 1'b0;
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// the table is written only by an update or by a scan clearing an entry
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_DONE || state_q == ST_SCAN))
		else $error("table written outside update");
	assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= Cw'(TableSize))
		else $error("entry count beyond table size");
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !out_vld_q || $past(out_vld_q))
		else $error("result before work");
endmodule

FILE: dv/tb_fiducial_tag_event_tracker_top.sv
// ----------------------------------------------------------------------------
// tb_fiducial_tag_event_tracker_top
// random and directed test of the tag event tracker against a tag table model
// ----------------------------------------------------------------------------
// Observations and checks are driven in bursts while the event side stalls
// on its own pattern. A class keeps a copy of the tag table, predicts the
// events of every accepted request and compares each event beat against them.
// ----------------------------------------------------------------------------
module tb_fiducial_tag_event_tracker_top;
	import fte_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NumTags = 32;

	class tag_event_board;
		logic [15:0] lim_pix;
		logic [30:0] lim_met;
		logic [15:0] vanish;
		int          used;
		entry_t      tbl [NumTags];
		evt_t        pending [$];
		int          errors;

		function new();
			lim_pix = 16'd80;
			lim_met = 31'd3277;
			vanish  = 16'd30;
			used    = 0;
			errors  = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_LIM_PIX: begin
					lim_pix = val[15:0];
				end
				REG_LIM_MET: begin
					lim_met = val[30:0];
				end
				REG_VANISH: begin
					vanish = val[15:0];
				end
				default: begin
				end
			endcase
		endfunction

		function evt_t make_evt(logic [2:0] code, req_t r);
			evt_t e;
			e.event_code   = code;
			e.out_family   = r.tag_family;
			e.out_tag      = r.tag_number;
			e.out_center_x = r.pos_x;
			e.out_center_y = r.pos_y;
			e.out_trans_x  = r.trans_x;
			e.out_trans_y  = r.trans_y;
			e.out_trans_z  = r.trans_z;
			e.run_last     = 1'b1;
			return e;
		endfunction

		function logic [63:0] sq_dist(longint a, longint b);
			logic [63:0] d;
			d = (a >= b) ? 64'(a - b) : 64'(b - a);
			return d * d;
		endfunction

		function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
			logic [64:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[64] ? '1 : s[63:0];
		endfunction

		function void note_request(req_t r);
			evt_t        e;
			int          hit;
			int          n;
			logic [2:0]  code;
			logic [63:0] dp, dm;
			if (r.req_type) begin
				n = 0;
				for (int i = 0; i < used && n < MaxResults; i++) begin
					if (tbl[i].active && (r.frame_number - tbl[i].seen) > {16'd0, vanish}) begin
						e.event_code   = EV_GONE;
						e.out_family   = tbl[i].family;
						e.out_tag      = tbl[i].tag;
						e.out_center_x = tbl[i].cx;
						e.out_center_y = tbl[i].cy;
						e.out_trans_x  = tbl[i].tx;
						e.out_trans_y  = tbl[i].ty;
						e.out_trans_z  = tbl[i].tz;
						e.run_last     = 1'b0;
						pending.push_back(e);
						tbl[i].active = 1'b0;
						n++;
					end
				end
				if (n == 0) begin
					e = '0;
					e.event_code = EV_NONE;
					pending.push_back(e);
				end
				pending[pending.size() - 1].run_last = 1'b1;
				return;
			end
			hit = -1;
			for (int i = 0; i < used; i++) begin
				if (tbl[i].tag == r.tag_number && tbl[i].family == r.tag_family) begin
					hit = i;
					break;
				end
			end
			if (hit < 0) begin
				if (used >= NumTags) begin
					pending.push_back(make_evt(EV_DROPPED, r));
					return;
				end
				hit = used++;
				tbl[hit].family = r.tag_family;
				tbl[hit].tag    = r.tag_number;
				tbl[hit].active = 1'b0;
			end
			code = EV_NONE;
			if (!tbl[hit].active) begin
				code = EV_APPEARED;
				tbl[hit].active = 1'b1;
			end else begin
				dp = sq_dist(r.pos_x, tbl[hit].cx) + sq_dist(r.pos_y, tbl[hit].cy);
				dm = sq_dist(longint'($signed(r.trans_x)), longint'($signed(tbl[hit].tx)));
				dm = add_sat(dm, sq_dist(longint'($signed(r.trans_y)),
					longint'($signed(tbl[hit].ty))));
				dm = add_sat(dm, sq_dist(longint'($signed(r.trans_z)),
					longint'($signed(tbl[hit].tz))));
				if (dp > 64'(lim_pix) * 64'(lim_pix) || dm > 64'(lim_met) * 64'(lim_met))
					code = EV_MOVED;
			end
			tbl[hit].cx   = r.pos_x;
			tbl[hit].cy   = r.pos_y;
			tbl[hit].tx   = r.trans_x;
			tbl[hit].ty   = r.trans_y;
			tbl[hit].tz   = r.trans_z;
			tbl[hit].seen = r.frame_number;
			pending.push_back(make_evt(code, r));
		endfunction

		function void check_event(evt_t got);
			evt_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected event beat %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("event mismatch: expected %h actual %h", want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	fte_if #(.payload_t(req_t)) req ();
	fte_if #(.payload_t(evt_t)) evt ();
	fte_if #(.payload_t(cfg_t)) cfg ();

	fiducial_tag_event_tracker_top dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .evt(evt.source), .cfg(cfg.sink)
	);

	tag_event_board board;
	int  idle_cycles = 0;
	bit  hold_long;
	bit  stall_on;
	logic [31:0] frame_now;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		board = new();
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// receiver stall pattern, with one long hold-off when asked
	initial begin
		int k;
		k = 0;
		evt.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			k++;
			if (hold_long)
				evt.ready <= 1'b0;
			else if (stall_on)
				evt.ready <= (k % 7 < 4) || ($urandom_range(0, 3) == 0);
			else
				evt.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				board.note_request(req.data);
			if (evt.valid && evt.ready)
				board.check_event(evt.data);
			if ((req.valid && req.ready) || (evt.valid && evt.ready) ||
				(cfg.valid && cfg.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 20000) begin
				$display("fiducial_tag_event_tracker_top test failed");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg.data  <= '{index: idx, data: val};
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		board.set_reg(idx, val);
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// keeps valid high across back-to-back beats when keep is set
	task automatic send(req_t r, bit keep);
		req.data  <= r;
		req.valid <= 1'b1;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		if (!keep) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	function automatic req_t obs(logic [3:0] fam, logic [15:0] tag);
		req_t r;
		r.req_type     = 1'b0;
		r.tag_family   = fam;
		r.tag_number   = tag;
		r.pos_x        = 16'($urandom);
		r.pos_y        = 16'($urandom);
		r.trans_x      = $urandom;
		r.trans_y      = $urandom;
		r.trans_z      = $urandom;
		r.frame_number = frame_now;
		r.last_of_frame = 1'($urandom);
		return r;
	endfunction

	function automatic req_t check_req();
		req_t r;
		r = obs(4'($urandom), 16'($urandom));
		r.req_type = 1'b1;
		return r;
	endfunction

	// small moves around the last position so both outcomes occur
	function automatic req_t near(req_t r);
		r.pos_x    = r.pos_x + 16'($urandom_range(0, 8));
		r.pos_y    = r.pos_y - 16'($urandom_range(0, 8));
		r.trans_x  = r.trans_x + $urandom_range(0, 3000);
		r.frame_number = frame_now;
		return r;
	endfunction

	initial begin
		req_t r, last [8];
		int   sent, burst;
		req.valid = 1'b0;
		req.data = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		hold_long = 1'b0;
		stall_on = 1'b0;
		frame_now = 32'd100;
		@(posedge arst_n);
		@(negedge clk);

		// directed: extremes, appear, move, none, check
		r = obs(4'd0, 16'd0);
		r.pos_x = 16'd0; r.pos_y = 16'd0;
		r.trans_x = 32'h8000_0000; r.trans_y = 32'h8000_0000; r.trans_z = 32'h8000_0000;
		send(r, 0);
		r.trans_x = 32'h7fff_ffff; r.trans_y = 32'h7fff_ffff; r.trans_z = 32'h7fff_ffff;
		r.pos_x = 16'hffff; r.pos_y = 16'hffff;
		send(r, 0);
		send(r, 0);
		r = obs(4'd15, 16'hffff);
		r.frame_number = 32'hffff_fff0;
		send(r, 0);
		send(near(r), 0);
		frame_now = 32'd200;
		send(check_req(), 0);
		send(check_req(), 0);
		drain();

		// fill the table past its size so later tags are dropped
		stall_on = 1'b1;
		for (int i = 0; i < 34; i++)
			send(obs(4'(i % 10), 16'(i)), i < 33);
		drain();
		write_reg(REG_VANISH, 32'd0);
		write_reg(REG_LIM_PIX, 32'd0);
		write_reg(REG_LIM_MET, 32'd0);
		frame_now = 32'd201;
		send(obs(4'd1, 16'd1), 0);
		send(check_req(), 0);
		drain();
		write_reg(REG_LIM_PIX, 32'hffff);
		write_reg(REG_LIM_MET, 32'h7fff_ffff);
		write_reg(REG_VANISH, 32'hffff);
		send(check_req(), 0);
		drain();

		// long receiver hold-off while requests keep coming
		hold_long = 1'b1;
		fork
			begin
				repeat (400) @(negedge clk);
				hold_long = 1'b0;
			end
			for (int i = 0; i < 12; i++) begin
				frame_now = frame_now + 40;
				send(check_req(), i < 11);
			end
		join
		drain();

		// random phases with different thresholds
		sent = 0;
		for (int ph = 0; ph < 3; ph++) begin
			write_reg(REG_LIM_PIX, $urandom_range(0, 64));
			write_reg(REG_LIM_MET, $urandom_range(0, 4000));
			write_reg(REG_VANISH, $urandom_range(0, 6));
			stall_on = (ph != 1);
			for (int k = 0; k < 8; k++)
				last[k] = obs(4'($urandom_range(0, 9)), 16'($urandom_range(0, 15)));
			while (sent < 40 * (ph + 1)) begin
				burst = $urandom_range(1, 6);
				for (int b = 0; b < burst; b++) begin
					case ($urandom_range(0, 9))
						0, 1: begin
							r = check_req();
						end
						2: begin
							r = obs(4'($urandom), 16'($urandom));
						end
						default: begin
							r = near(last[$urandom_range(0, 7)]);
						end
					endcase
					if ($urandom_range(0, 2) == 0)
						frame_now = frame_now + $urandom_range(1, 4);
					r.frame_number = frame_now;
					if (!r.req_type && r.tag_number < 16)
						for (int k = 0; k < 8; k++)
							if (last[k].tag_number == r.tag_number &&
								last[k].tag_family == r.tag_family)
								last[k] = r;
					send(r, b < burst - 1);
					sent++;
				end
				repeat ($urandom_range(0, 8)) @(negedge clk);
			end
			drain();
		end

		while (board.pending.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("fiducial_tag_event_tracker_top test passed");
		else
			$display("fiducial_tag_event_tracker_top test failed");
		$finish;
	end
endmodule

FILE: filelist.f
hw/rtl/fte_pkg.sv
hw/rtl/fte_if.sv
hw/rtl/fte_table.sv
hw/rtl/fte_dist.sv
hw/rtl/fiducial_tag_event_tracker_top.sv
dv/tb_fiducial_tag_event_tracker_top.sv
